@@ sv/uvt_pkg.sv @@
// ----------------------------------------------------------------------------
// uvt_pkg: shared types and constants
// Widths, register map, state encoding and saturation helper for the
// uncertain volatility tree rollback block.
// ----------------------------------------------------------------------------
package uvt_pkg;

	localparam int MAX_STEPS  = 256;
	localparam int LINE_DEPTH = 2 * MAX_STEPS + 1;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int STEPS_W    = 9;
	localparam int COEF_W     = 31;
	localparam int VAL_W      = 48;
	localparam int OPND_W     = 50;
	localparam int RES_W      = 52;

	localparam logic [COEF_W-1:0] ONE_Q30 = COEF_W'(32'h4000_0000);

	// register indexes on the config port
	localparam logic [2:0] REG_STEPS     = 3'd0;
	localparam logic [2:0] REG_DISCOUNT  = 3'd1;
	localparam logic [2:0] REG_SKEW      = 3'd2;
	localparam logic [2:0] REG_PROB_HIGH = 3'd3;
	localparam logic [2:0] REG_PROB_LOW  = 3'd4;

	// multiply operations of one node, in issue order
	localparam logic [2:0] OP_GAM_U = 3'd0;
	localparam logic [2:0] OP_GAM_L = 3'd1;
	localparam logic [2:0] OP_WGT_U = 3'd2;
	localparam logic [2:0] OP_WGT_L = 3'd3;
	localparam logic [2:0] OP_DSC_U = 3'd4;
	localparam logic [2:0] OP_DSC_L = 3'd5;

	// line read slots
	localparam logic [1:0] SLOT_UP  = 2'd0;
	localparam logic [1:0] SLOT_MID = 2'd1;
	localparam logic [1:0] SLOT_DN  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAF,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MUL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic [STEPS_W-1:0] steps;
		logic [COEF_W-1:0]  discount;
		logic [COEF_W-1:0]  skew;
		logic [COEF_W-1:0]  prob_high;
		logic [COEF_W-1:0]  prob_low;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       leaf_wr;
		logic       node_wr;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic [2:0] mul_op;
		logic       mul_wr;
	} cmd_t;

	typedef struct packed {
		logic level_zero;
		logic root;
		logic out_busy;
	} status_t;

	function automatic logic signed [VAL_W-1:0] sat48(input logic signed [RES_W-1:0] v);
		logic signed [RES_W-1:0] hi;
		logic signed [RES_W-1:0] lo;
		hi = RES_W'(48'sh7FFF_FFFF_FFFF);
		lo = -hi - RES_W'(1);
		if (v > hi)
			return VAL_W'(hi);
		else if (v < lo)
			return VAL_W'(lo);
		else
			return VAL_W'(v);
	endfunction

	function automatic logic [COEF_W-1:0] coef(input logic [COEF_W-1:0] c);
		return (c > ONE_Q30) ? ONE_Q30 : c;
	endfunction

endpackage

@@ sv/uvt_mul.sv @@
// ----------------------------------------------------------------------------
// uvt_mul: Q1.30 coefficient multiplier
// Product round(v*c/2^30), ties away from zero, split into two registered
// partial products on the magnitude.
// ----------------------------------------------------------------------------
module uvt_mul (
	input  logic                                  clk,
	input  logic signed [uvt_pkg::OPND_W-1:0]     v,
	input  logic        [uvt_pkg::COEF_W-1:0]     c,
	output logic signed [uvt_pkg::RES_W-1:0]      res
);

	localparam int HI_W = uvt_pkg::OPND_W - 30;
	localparam int PH_W = HI_W + uvt_pkg::COEF_W;
	localparam int PL_W = 30 + uvt_pkg::COEF_W;

	logic [uvt_pkg::OPND_W-1:0] mag;
	logic [PH_W-1:0]            prod_hi_s1;
	logic [PL_W-1:0]            prod_lo_s1;
	logic                       neg_s1;
	logic [PL_W:0]              rnd;
	logic [uvt_pkg::RES_W-1:0]  r;

	// magnitude and partial products
	assign mag = v[uvt_pkg::OPND_W-1] ? (~v + uvt_pkg::OPND_W'(1)) : v;

	always_ff @(posedge clk) begin
		prod_hi_s1 <= PH_W'(mag[uvt_pkg::OPND_W-1:30]) * PH_W'(c);
		prod_lo_s1 <= PL_W'(mag[29:0]) * PL_W'(c);
		neg_s1     <= v[uvt_pkg::OPND_W-1];
	end

	// round the low part and combine
	assign rnd = (PL_W+1)'(prod_lo_s1) + (PL_W+1)'(32'h2000_0000);
	assign r   = uvt_pkg::RES_W'(prod_hi_s1) + uvt_pkg::RES_W'(rnd[PL_W:30]);
	assign res = neg_s1 ? -signed'(r) : signed'(r);

endmodule

@@ sv/uvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// uvt_ctrl: node sequencer
// Steps each interior node through three line reads, six multiplies on the
// shared unit and the write back, writes leaves directly, and holds the input while busy.
// ----------------------------------------------------------------------------
module uvt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  uvt_pkg::status_t   st,
	output uvt_pkg::cmd_t      cmd
);

	uvt_pkg::state_t state_q, state_nx;
	logic [2:0]      op_q;
	logic            phase_q;

	// state register and multiply sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvt_pkg::ST_IDLE;
			op_q    <= uvt_pkg::OP_GAM_U;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == uvt_pkg::ST_RD3) begin
				op_q    <= uvt_pkg::OP_GAM_U;
				phase_q <= 1'b0;
			end else if (state_q == uvt_pkg::ST_MUL) begin
				phase_q <= ~phase_q;
				if (phase_q)
					op_q <= op_q + 3'd1;
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			uvt_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = st.level_zero ? uvt_pkg::ST_LEAF : uvt_pkg::ST_RD0;
			end
			uvt_pkg::ST_LEAF: begin
				if (!st.out_busy)
					state_nx = uvt_pkg::ST_IDLE;
			end
			uvt_pkg::ST_RD0: state_nx = uvt_pkg::ST_RD1;
			uvt_pkg::ST_RD1: state_nx = uvt_pkg::ST_RD2;
			uvt_pkg::ST_RD2: state_nx = uvt_pkg::ST_RD3;
			uvt_pkg::ST_RD3: state_nx = uvt_pkg::ST_MUL;
			uvt_pkg::ST_MUL: begin
				if (phase_q && op_q == uvt_pkg::OP_DSC_L)
					state_nx = uvt_pkg::ST_WB;
			end
			uvt_pkg::ST_WB: begin
				if (!st.out_busy)
					state_nx = uvt_pkg::ST_IDLE;
			end
			default: state_nx = uvt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.mul_op  = op_q;
		in_stall    = (state_q != uvt_pkg::ST_IDLE);
		unique case (state_q)
			uvt_pkg::ST_IDLE: cmd.load = in_valid;
			uvt_pkg::ST_LEAF: cmd.leaf_wr = !st.out_busy;
			uvt_pkg::ST_RD0:  cmd.rd_sel = uvt_pkg::SLOT_UP;
			uvt_pkg::ST_RD1: begin
				cmd.rd_sel  = uvt_pkg::SLOT_MID;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = uvt_pkg::SLOT_UP;
			end
			uvt_pkg::ST_RD2: begin
				cmd.rd_sel  = uvt_pkg::SLOT_DN;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = uvt_pkg::SLOT_MID;
			end
			uvt_pkg::ST_RD3: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = uvt_pkg::SLOT_DN;
			end
			uvt_pkg::ST_MUL:  cmd.mul_wr = phase_q;
			uvt_pkg::ST_WB:   cmd.node_wr = !st.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

@@ sv/uvt_dp.sv @@
// ----------------------------------------------------------------------------
// uvt_dp: rollback datapath
// Line stores, tree position counters, node arithmetic around the shared
// multiplier, and the result register.
// ----------------------------------------------------------------------------
module uvt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  uvt_pkg::cfg_t                        cfg,
	input  uvt_pkg::cmd_t                        cmd,
	output uvt_pkg::status_t                     st,
	input  logic signed [uvt_pkg::VAL_W-1:0]     cashflow,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [uvt_pkg::VAL_W-1:0]     upper_value,
	output logic signed [uvt_pkg::VAL_W-1:0]     lower_value,
	output logic signed [uvt_pkg::VAL_W-1:0]     curvature,
	output logic                                 is_root
);

	localparam int AW = uvt_pkg::ADDR_W;
	localparam int SW = uvt_pkg::STEPS_W;
	localparam int VW = uvt_pkg::VAL_W;
	localparam int OW = uvt_pkg::OPND_W;
	localparam int RW = uvt_pkg::RES_W;
	localparam int CW = uvt_pkg::COEF_W;

	logic signed [VW-1:0] upper_mem [uvt_pkg::LINE_DEPTH];
	logic signed [VW-1:0] lower_mem [uvt_pkg::LINE_DEPTH];
	logic signed [VW-1:0] rd_u_q, rd_l_q;

	logic [SW-1:0] level_q;
	logic [AW-1:0] node_q;
	logic [SW-1:0] lc_q;
	logic [AW-1:0] i_q, last_q;
	logic          n_zero_q;
	logic signed [VW-1:0] cash_q;

	logic signed [VW-1:0] up_u_q, mid_u_q, dn_u_q, up_l_q, mid_l_q, dn_l_q;
	logic signed [VW-1:0] g_u_q, g_l_q, b_u_q, b_l_q;
	logic signed [OW-1:0] w_u_q, w_l_q;

	logic [SW-1:0] s_eff, lc, n;
	logic [AW-1:0] last_leaf, last_node, idx_leaf, idx_node;
	logic [CW-1:0] c_a, c_d, c_ph, c_pl;
	logic signed [OW-1:0] mv;
	logic [CW-1:0]        mc;
	logic signed [RW-1:0] mres, sum_u, sum_l;
	logic                 we;
	logic [AW-1:0]        ra;
	logic signed [VW-1:0] wd_u, wd_l;
	logic                 out_valid_q;

	// effective step count and node position for the next item
	always_comb begin
		if (cfg.steps == '0)
			s_eff = SW'(1);
		else if (32'(cfg.steps) > uvt_pkg::MAX_STEPS)
			s_eff = SW'(uvt_pkg::MAX_STEPS);
		else
			s_eff = cfg.steps;
		last_leaf = {s_eff, 1'b0};
		idx_leaf  = (node_q > last_leaf) ? last_leaf : node_q;
		lc        = (level_q > s_eff) ? s_eff : level_q;
		n         = s_eff - lc;
		last_node = {n, 1'b0};
		idx_node  = (node_q > last_node) ? last_node : node_q;
	end

	// clamped coefficients
	assign c_a  = uvt_pkg::coef(cfg.skew);
	assign c_d  = uvt_pkg::coef(cfg.discount);
	assign c_ph = uvt_pkg::coef(cfg.prob_high);
	assign c_pl = uvt_pkg::coef(cfg.prob_low);

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cash_q   <= cashflow;
			lc_q     <= lc;
			n_zero_q <= (n == '0);
			if (level_q == '0) begin
				i_q    <= idx_leaf;
				last_q <= last_leaf;
			end else begin
				i_q    <= idx_node;
				last_q <= last_node;
			end
		end
	end

	// tree position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			node_q  <= '0;
		end else if (cmd.leaf_wr) begin
			if (i_q >= last_q) begin
				level_q <= SW'(1);
				node_q  <= '0;
			end else begin
				node_q  <= i_q + AW'(1);
			end
		end else if (cmd.node_wr) begin
			if (i_q >= last_q) begin
				node_q  <= '0;
				level_q <= n_zero_q ? '0 : lc_q + SW'(1);
			end else begin
				node_q  <= i_q + AW'(1);
				level_q <= lc_q;
			end
		end
	end

	// line stores, one write and one registered read each
	assign we   = cmd.leaf_wr | cmd.node_wr;
	assign ra   = i_q + AW'(cmd.rd_sel);
	assign wd_u = cmd.leaf_wr ? cash_q : b_u_q;
	assign wd_l = cmd.leaf_wr ? cash_q : b_l_q;

	always_ff @(posedge clk) begin
		if (we) begin
			upper_mem[i_q] <= wd_u;
			lower_mem[i_q] <= wd_l;
		end
		rd_u_q <= upper_mem[ra];
		rd_l_q <= lower_mem[ra];
	end

	// capture the three neighbors
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_sel)
				uvt_pkg::SLOT_UP: begin
					up_u_q <= rd_u_q;
					up_l_q <= rd_l_q;
				end
				uvt_pkg::SLOT_MID: begin
					mid_u_q <= rd_u_q;
					mid_l_q <= rd_l_q;
				end
				default: begin
					dn_u_q <= rd_u_q;
					dn_l_q <= rd_l_q;
				end
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			uvt_pkg::OP_GAM_U: begin
				mv = OW'(dn_u_q) - OW'(up_u_q);
				mc = c_a;
			end
			uvt_pkg::OP_GAM_L: begin
				mv = OW'(dn_l_q) - OW'(up_l_q);
				mc = c_a;
			end
			uvt_pkg::OP_WGT_U: begin
				mv = OW'(g_u_q);
				mc = g_u_q[VW-1] ? c_pl : c_ph;
			end
			uvt_pkg::OP_WGT_L: begin
				mv = OW'(g_l_q);
				mc = g_l_q[VW-1] ? c_ph : c_pl;
			end
			uvt_pkg::OP_DSC_U: begin
				mv = OW'(mid_u_q) + w_u_q;
				mc = c_d;
			end
			default: begin
				mv = OW'(mid_l_q) + w_l_q;
				mc = c_d;
			end
		endcase
	end

	uvt_mul u_mul (
		.clk (clk),
		.v   (mv),
		.c   (mc),
		.res (mres)
	);

	// second differences without the skew term
	assign sum_u = RW'(up_u_q) + RW'(dn_u_q) - (RW'(mid_u_q) <<< 1);
	assign sum_l = RW'(up_l_q) + RW'(dn_l_q) - (RW'(mid_l_q) <<< 1);

	// multiply results into gamma, weight and bound registers
	always_ff @(posedge clk) begin
		if (cmd.mul_wr) begin
			case (cmd.mul_op)
				uvt_pkg::OP_GAM_U: g_u_q <= uvt_pkg::sat48(sum_u + mres);
				uvt_pkg::OP_GAM_L: g_l_q <= uvt_pkg::sat48(sum_l + mres);
				uvt_pkg::OP_WGT_U: w_u_q <= OW'(mres);
				uvt_pkg::OP_WGT_L: w_l_q <= OW'(mres);
				uvt_pkg::OP_DSC_U: b_u_q <= uvt_pkg::sat48(RW'(cash_q) + mres);
				default:           b_l_q <= uvt_pkg::sat48(RW'(cash_q) + mres);
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (we)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.leaf_wr) begin
			upper_value <= cash_q;
			lower_value <= cash_q;
			curvature   <= '0;
			is_root     <= 1'b0;
		end else if (cmd.node_wr) begin
			upper_value <= b_u_q;
			lower_value <= b_l_q;
			curvature   <= g_u_q;
			is_root     <= n_zero_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign st.level_zero = (level_q == '0);
	assign st.root       = n_zero_q;
	assign st.out_busy   = out_valid_q & out_stall;

endmodule

@@ sv/uncertain_vol_tree_rollback.sv @@
// ----------------------------------------------------------------------------
// uncertain_vol_tree_rollback: uncertain volatility trinomial tree rollback
// Rolls upper and lower price bounds back through a trinomial tree.
// ----------------------------------------------------------------------------
// Usage: program steps, discount, skew and the two probability weights over
// the config port while idle. Then send 2S+1 leaf payoffs on the input
// channel (cashflow, top node first), followed by one cashflow per interior
// node, level by level toward the root. Every input transfer yields one
// output transfer carrying both bounds and the upper-bound gamma; the root
// result has is_root set, after which the block expects leaves again.
// Sequence: a leaf result is registered in the leaf state entered on its
// input transfer. An interior node passes RD0 to RD3 for three reads of each
// line store's single read port, MUL for six products through the shared
// multiplier, and WB for write back. The input is taken only in the idle
// state that follows, so one item is in flight at a time and the block
// takes no new item before the last one is written back.
// A stalled output holds its result; the block still takes the next item
// while that result waits, and holds the new result, keeping the input
// stalled, until the waiting one has transferred.
// Reset returns config, controller, counters and out_valid to defaults and the
// tree to leaf loading; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uncertain_vol_tree_rollback (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [4:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [uvt_pkg::VAL_W-1:0]     cashflow,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [uvt_pkg::VAL_W-1:0]     upper_value,
	output logic signed [uvt_pkg::VAL_W-1:0]     lower_value,
	output logic signed [uvt_pkg::VAL_W-1:0]     curvature,
	output logic                                 is_root
);

	uvt_pkg::cfg_t    cfg_q;
	uvt_pkg::cmd_t    cmd;
	uvt_pkg::status_t st;
	logic             wr_en;
	logic [2:0]       reg_idx;

	// config register writes
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps     <= uvt_pkg::STEPS_W'(100);
			cfg_q.discount  <= uvt_pkg::ONE_Q30;
			cfg_q.skew      <= '0;
			cfg_q.prob_high <= '0;
			cfg_q.prob_low  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				uvt_pkg::REG_STEPS:     cfg_q.steps     <= pwdata[uvt_pkg::STEPS_W-1:0];
				uvt_pkg::REG_DISCOUNT:  cfg_q.discount  <= pwdata[uvt_pkg::COEF_W-1:0];
				uvt_pkg::REG_SKEW:      cfg_q.skew      <= pwdata[uvt_pkg::COEF_W-1:0];
				uvt_pkg::REG_PROB_HIGH: cfg_q.prob_high <= pwdata[uvt_pkg::COEF_W-1:0];
				uvt_pkg::REG_PROB_LOW:  cfg_q.prob_low  <= pwdata[uvt_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// config register reads
	always_comb begin
		unique case (reg_idx)
			uvt_pkg::REG_STEPS:     prdata = 32'(cfg_q.steps);
			uvt_pkg::REG_DISCOUNT:  prdata = 32'(cfg_q.discount);
			uvt_pkg::REG_SKEW:      prdata = 32'(cfg_q.skew);
			uvt_pkg::REG_PROB_HIGH: prdata = 32'(cfg_q.prob_high);
			uvt_pkg::REG_PROB_LOW:  prdata = 32'(cfg_q.prob_low);
			default:                prdata = '0;
		endcase
	end

	uvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	uvt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.st          (st),
		.cashflow    (cashflow),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.upper_value (upper_value),
		.lower_value (lower_value),
		.curvature   (curvature),
		.is_root     (is_root)
	);

	// one item in flight: a transfer is followed by a busy input
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// a result is only loaded when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.leaf_wr || cmd.node_wr) |-> !st.out_busy)
		else $error("result register overwritten while stalled");

	// the root ends the tree and returns to leaf loading
	a_root_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.node_wr && st.root) |=> st.level_zero)
		else $error("tree not restarted after root");

endmodule
